// ===== hdl/terminal_command_parser_macros.svh =====
// Assertion macros shared by the terminal command parser RTL.
`ifndef TERMINAL_COMMAND_PARSER_MACROS_SVH
`define TERMINAL_COMMAND_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CMDP_ASSERT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CMDP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/cmdp_pkg.sv =====
// Types, command codes and prefix tables for the terminal command parser.
package cmdp_pkg;

   localparam int PREFIX_COUNT   = 6;
   localparam int PREFIX_MAX_LEN = 9;

   localparam logic [7:0] MARK_CHAR  = 8'h25;
   localparam logic [7:0] SPACE_CHAR = 8'h20;
   localparam logic [7:0] DIGIT_LOW  = 8'h30;
   localparam logic [7:0] DIGIT_HIGH = 8'h39;

   typedef enum logic [2:0] {
      CMD_HELP       = 3'd0,
      CMD_BLINK      = 3'd1,
      CMD_FADE       = 3'd2,
      CMD_FADE_ON    = 3'd3,
      CMD_FADE_OFF   = 3'd4,
      CMD_STOP       = 3'd5,
      CMD_UNKNOWN    = 3'd6,
      CMD_BAD_VALUES = 3'd7
   } cmd_code_type;

   typedef logic [0:PREFIX_MAX_LEN-1][7:0] prefix_row_type;

   // Prefix text, first character at index 0, zero padded.
   localparam prefix_row_type PREFIX_TEXT [PREFIX_COUNT] = '{
      '{8'h68, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // "h\n"
      '{8'h62, 8'h6C, 8'h69, 8'h6E, 8'h6B, 8'h20, 8'h00, 8'h00, 8'h00},  // "blink "
      '{8'h66, 8'h61, 8'h64, 8'h65, 8'h20, 8'h25, 8'h00, 8'h00, 8'h00},  // "fade %"
      '{8'h66, 8'h61, 8'h64, 8'h65, 8'h20, 8'h6F, 8'h6E, 8'h20, 8'h00},  // "fade on "
      '{8'h66, 8'h61, 8'h64, 8'h65, 8'h20, 8'h6F, 8'h66, 8'h66, 8'h20},  // "fade off "
      '{8'h73, 8'h74, 8'h6F, 8'h70, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00}   // "stop\n"
   };

   localparam logic [3:0] PREFIX_LEN [PREFIX_COUNT] = '{
      4'd2, 4'd6, 4'd6, 4'd8, 4'd9, 4'd5
   };

   // One word held in the input register.
   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
      logic       last_byte;
   } cmdp_item_type;

   // One result of a finished message.
   typedef struct packed {
      cmd_code_type command_code;
      logic [31:0]  first_value;
      logic [31:0]  second_value;
   } cmdp_result_type;

endpackage

// ===== hdl/cmdp_in_reg.sv =====
// Input register of the terminal command parser.
module cmdp_in_reg
   import cmdp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_in_byte,
   input  logic          req_last_byte,
   input  logic          advance,
   output cmdp_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;

   // Full and not draining this cycle.
   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         byte_ff <= req_in_byte;
         last_ff <= req_last_byte;
      end
   end

   assign item = '{valid: valid_ff, in_byte: byte_ff, last_byte: last_ff};

endmodule

// ===== hdl/cmdp_scan.sv =====
// Per-byte scanner: prefix match, mark and digit checks, value accumulate, verdict.
`include "terminal_command_parser_macros.svh"

module cmdp_scan
   import cmdp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 256
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  cmdp_item_type   item,
   output cmdp_result_type result
);

   localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [PREFIX_COUNT-1:0]  alive_ff, alive_in;
   logic [2:0]               mark_ff, mark_in;
   logic [POS_W-1:0]         lm_ff, lm_in;
   logic [1:0][31:0]         acc_ff, acc_in;
   logic                     digits_ff, digits_in;
   logic                     gap_ff, gap_in;
   logic [1:0][31:0]         held_ff, held_in;

   logic [7:0]               b;
   logic                     is_mark, is_digit;
   logic [3:0]               p_small;
   logic [POS_W:0]           p_ext, lm_plus1, lm_plus2;
   logic                     acc_idx;
   cmd_code_type             match_code, code;
   logic [2:0]               need;
   logic                     value_ok;

   assign b        = item.in_byte;
   assign is_mark  = (b == MARK_CHAR);
   assign is_digit = (b >= DIGIT_LOW) && (b <= DIGIT_HIGH);
   assign p_small  = (pos_ff < POS_W'(PREFIX_MAX_LEN)) ? pos_ff[3:0] : 4'd0;
   assign p_ext    = {1'b0, pos_ff};
   assign lm_plus1 = {1'b0, lm_ff} + (POS_W+1)'(1);
   assign lm_plus2 = {1'b0, lm_ff} + (POS_W+1)'(2);
   assign acc_idx  = (mark_ff == 3'd3);

   // Next message state for this byte.
   always_comb begin
      pos_in    = pos_ff;
      alive_in  = alive_ff;
      mark_in   = mark_ff;
      lm_in     = lm_ff;
      acc_in    = acc_ff;
      digits_in = digits_ff;
      gap_in    = gap_ff;
      if (pos_ff == POS_W'(MAX_MESSAGE_BYTES)) begin
         alive_in = '0;
      end else begin
         for (int k = 0; k < PREFIX_COUNT; k++) begin
            if ((pos_ff < POS_W'(PREFIX_LEN[k])) && (b != PREFIX_TEXT[k][p_small])) begin
               alive_in[k] = 1'b0;
            end
         end
         if (is_mark) begin
            if ((mark_ff == 3'd2) && (p_ext != lm_plus2)) begin
               gap_in = 1'b0;
            end
            if (mark_ff != 3'd7) begin
               mark_in = mark_ff + 3'd1;
            end
            lm_in = pos_ff;
         end else begin
            if ((mark_ff == 3'd2) && (p_ext == lm_plus1) && (b != SPACE_CHAR)) begin
               gap_in = 1'b0;
            end
            if ((mark_ff == 3'd1) || (mark_ff == 3'd3)) begin
               if (is_digit) begin
                  acc_in[acc_idx] = (acc_ff[acc_idx] << 3) + (acc_ff[acc_idx] << 1)
                                    + {28'd0, b[3:0]};
               end else begin
                  digits_in = 1'b0;
               end
            end
         end
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Verdict on the updated state; first live prefix that fits wins.
   always_comb begin
      match_code = CMD_UNKNOWN;
      for (int k = PREFIX_COUNT - 1; k >= 0; k--) begin
         if (alive_in[k] && (pos_in >= POS_W'(PREFIX_LEN[k]))) begin
            match_code = cmd_code_type'(3'(k));
         end
      end
      case (match_code)
         CMD_BLINK, CMD_FADE:        need = 3'd4;
         CMD_FADE_ON, CMD_FADE_OFF:  need = 3'd2;
         default:                    need = 3'd0;
      endcase
      value_ok = (mark_in == need)
                 && ({1'b0, lm_in} + (POS_W+1)'(2) == {1'b0, pos_in})
                 && digits_in
                 && ((need == 3'd2) || gap_in);
      code    = match_code;
      held_in = held_ff;
      if (need != 3'd0) begin
         if (value_ok && advance && item.last_byte) begin
            held_in[0] = acc_in[0];
            held_in[1] = (need == 3'd4) ? acc_in[1] : 32'd0;
         end
         if (!value_ok) begin
            code = CMD_BAD_VALUES;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         alive_ff  <= '1;
         mark_ff   <= '0;
         lm_ff     <= '0;
         acc_ff    <= '0;
         digits_ff <= 1'b1;
         gap_ff    <= 1'b1;
         held_ff   <= '0;
      end else if (advance) begin
         held_ff <= held_in;
         if (item.last_byte) begin
            pos_ff    <= '0;
            alive_ff  <= '1;
            mark_ff   <= '0;
            lm_ff     <= '0;
            acc_ff    <= '0;
            digits_ff <= 1'b1;
            gap_ff    <= 1'b1;
         end else begin
            pos_ff    <= pos_in;
            alive_ff  <= alive_in;
            mark_ff   <= mark_in;
            lm_ff     <= lm_in;
            acc_ff    <= acc_in;
            digits_ff <= digits_in;
            gap_ff    <= gap_in;
         end
      end
   end

   assign result = '{command_code: code, first_value: held_in[0], second_value: held_in[1]};

   `CMDP_ASSERT(held_only_on_good_values, held_in != held_ff, advance && item.last_byte && value_ok && (need != 3'd0), "held values changed without a good value command")
   `CMDP_ASSERT(marks_never_drop_midmessage, advance && !item.last_byte, mark_in >= mark_ff, "mark count dropped inside a message")
   `CMDP_ASSERT_NEXT(state_clear_after_last, advance && item.last_byte, (pos_ff == '0) && (alive_ff == '1) && (mark_ff == '0), "message state not cleared after last word")

endmodule

// ===== hdl/terminal_command_parser.sv =====
// Top level of the terminal command parser: input register, scanner, result register.
//
// Usage:
//   req_*  carries one message byte per word (req_in_byte) and req_last_byte
//          on the final byte. A word is taken when req_valid is high and
//          req_stall is low.
//   rsp_*  carries one result word per message: rsp_command_code and the
//          values of the last good value command (rsp_first_value,
//          rsp_second_value). Taken when rsp_valid is high, rsp_stall low.
//   Bytes other than the last one produce no result word.
//
// Timing: a byte enters the input register; the scanner then updates the
// message state and, for a last byte, loads the result register, from which
// the result word is driven. One byte per cycle is sustained while no final
// byte waits under rsp_stall; the loop on the message state sets that rate.
//
// Stall: while a result waits under rsp_stall, non-final bytes keep flowing;
// a final byte waits in the input register, which then raises req_stall.
// Reset (synchronous, active high) empties both registers, clears message
// state and zeroes the held values.
`include "terminal_command_parser_macros.svh"

module terminal_command_parser
   import cmdp_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_command_code,
   output logic [31:0] rsp_first_value,
   output logic [31:0] rsp_second_value
);

   cmdp_item_type   item;
   cmdp_result_type result;
   logic            advance;
   logic            rsp_valid_ff, rsp_valid_in;
   cmdp_result_type rsp_ff;

   // A last byte may only move when the result register can take it.
   assign advance = item.valid && (!item.last_byte || !rsp_valid_ff || !rsp_stall);

   cmdp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .item          (item)
   );

   cmdp_scan #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   assign rsp_valid_in = (advance && item.last_byte) ? 1'b1
                       : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item.last_byte) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_ff.command_code;
   assign rsp_first_value  = rsp_ff.first_value;
   assign rsp_second_value = rsp_ff.second_value;

   `CMDP_ASSERT(no_overwrite_of_waiting_result, rsp_valid_ff && rsp_stall, !(advance && item.last_byte), "result register overwritten while stalled")
   `CMDP_ASSERT(advance_needs_item, advance, item.valid, "scanner advanced with empty input register")
   `CMDP_ASSERT_NEXT(last_byte_gives_result, advance && item.last_byte, rsp_valid_ff, "last byte did not load a result")

endmodule

// ===== tb/sv/tb_terminal_command_parser.sv =====
// Self-checking testbench for the terminal command parser: directed and random messages.
module tb_terminal_command_parser;
   import cmdp_pkg::*;

   localparam int MAX_BYTES    = 256;
   localparam int RANDOM_BYTES = 260;     // bytes in the random part
   localparam int CYCLE_LIMIT  = 300000;  // slowest legal run is far below this
   localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
   localparam int TAIL_CYCLES  = 8;       // quiet time after the last result

   // One expected result word.
   typedef struct {
      cmd_code_type code;
      logic [31:0]  first;
      logic [31:0]  second;
   } cmd_result_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte   = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [2:0]  rsp_command_code;
   logic [31:0] rsp_first_value;
   logic [31:0] rsp_second_value;

   terminal_command_parser #(
      .MAX_MESSAGE_BYTES(MAX_BYTES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command_code(rsp_command_code),
      .rsp_first_value (rsp_first_value),
      .rsp_second_value(rsp_second_value)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Parser prediction: message scan state plus the values held across
   // messages. Updated once per accepted byte.
   // ---------------------------------------------------------------------
   int unsigned    scan_pos;
   logic [5:0]     scan_alive;       // one bit per prefix still matching
   int unsigned    scan_marks;       // '%' count, saturates at 7
   int unsigned    scan_mark_pos;    // position of the latest '%'
   logic [31:0]    scan_value [2];
   bit             scan_digits_ok;
   bit             scan_gap_ok;      // "% %" between the two values
   logic [31:0]    held_first;
   logic [31:0]    held_second;
   cmd_result_type pending_results [$];

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   int unsigned sent_bytes  = 0;
   bit          tx_idle_on  = 1'b1;
   bit          rx_idle_on  = 1'b1;
   bit          hold_request = 1'b0;
   int unsigned hold_left    = 0;
   logic [7:0]  msg_buf [$];       // message being assembled

   function automatic void clear_scan();
      scan_pos       = 0;
      scan_alive     = '1;
      scan_marks     = 0;
      scan_mark_pos  = 0;
      scan_value[0]  = '0;
      scan_value[1]  = '0;
      scan_digits_ok = 1'b1;
      scan_gap_ok    = 1'b1;
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic last);
      cmd_result_type r;
      int             k;
      int unsigned    slot;
      int unsigned    need;
      bit             ok;
      // Bytes past the size limit are not looked at; they just kill every prefix.
      if (scan_pos >= MAX_BYTES) begin
         scan_alive = '0;
      end else begin
         for (k = 0; k < PREFIX_COUNT; k++) begin
            if (scan_pos < PREFIX_LEN[k] && b != PREFIX_TEXT[k][scan_pos])
               scan_alive[k] = 1'b0;
         end
         if (b == MARK_CHAR) begin
            // third mark must sit right after "% "
            if (scan_marks == 2 && scan_pos != scan_mark_pos + 2)
               scan_gap_ok = 1'b0;
            if (scan_marks < 7)
               scan_marks++;
            scan_mark_pos = scan_pos;
         end else begin
            if (scan_marks == 2 && scan_pos == scan_mark_pos + 1 && b != SPACE_CHAR)
               scan_gap_ok = 1'b0;
            if (scan_marks == 1 || scan_marks == 3) begin
               slot = (scan_marks == 3) ? 1 : 0;
               if (b >= DIGIT_LOW && b <= DIGIT_HIGH)
                  scan_value[slot] = scan_value[slot] * 32'd10 + (b - DIGIT_LOW);
               else
                  scan_digits_ok = 1'b0;
            end
         end
         scan_pos++;
      end

      if (last) begin
         // lowest-numbered matching prefix wins
         r.code = CMD_UNKNOWN;
         for (k = PREFIX_COUNT - 1; k >= 0; k--) begin
            if (scan_alive[k] && scan_pos >= PREFIX_LEN[k])
               r.code = cmd_code_type'(k);
         end
         case (r.code)
            CMD_BLINK, CMD_FADE:       need = 4;
            CMD_FADE_ON, CMD_FADE_OFF: need = 2;
            default:                   need = 0;
         endcase
         if (need != 0) begin
            ok = scan_marks == need && scan_mark_pos + 2 == scan_pos && scan_digits_ok
                 && (need == 2 || scan_gap_ok);
            if (ok) begin
               held_first  = scan_value[0];
               held_second = (need == 4) ? scan_value[1] : 32'd0;
            end else begin
               r.code = CMD_BAD_VALUES;
            end
         end
         r.first  = held_first;
         r.second = held_second;
         pending_results.push_back(r);
         clear_scan();
      end
   endfunction

   // ---------------------------------------------------------------------
   // Housekeeping: cycle count and timeout.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // ---------------------------------------------------------------------
   // Result side. Stall changes at the rising edge; the word is sampled at
   // the falling edge, where valid/stall/payload are settled for the next
   // rising edge, which is the one that takes the word.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rx_idle_on && ($urandom_range(99) < 33);
      end
   end

   always @(negedge clock) begin : check_words
      cmd_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("result word with nothing pending, code %0d",
                                   rsp_command_code));
         end else begin
            want = pending_results.pop_front();
            if (rsp_command_code !== want.code)
               report_error($sformatf("command_code got %0d expected %0d",
                                      rsp_command_code, want.code));
            if (rsp_first_value !== want.first)
               report_error($sformatf("first_value got %0d expected %0d",
                                      rsp_first_value, want.first));
            if (rsp_second_value !== want.second)
               report_error($sformatf("second_value got %0d expected %0d",
                                      rsp_second_value, want.second));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Byte side. Valid and payload move only at the rising edge. Stall is
   // looked at on the falling edge; if low there, the next rising edge
   // takes the word and the prediction is updated right away.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic last);
      bit taken;
      while (tx_idle_on && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= b;
      req_last_byte <= last;
      do begin
         @(negedge clock);
         taken = (req_stall == 1'b0);
         if (taken)
            scan_byte(b, last);
         @(posedge clock);
      end while (!taken);
      sent_bytes++;
   endtask

   // Sends msg_buf as one message, last marker on its final byte.
   task automatic send_message();
      int i;
      for (i = 0; i < msg_buf.size(); i++)
         send_byte(msg_buf[i], i == msg_buf.size() - 1);
      msg_buf.delete();
   endtask

   // Sender pause: nothing offered until every pending result is back.
   task automatic wait_results_done();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         msg_buf.push_back(s[i]);
   endtask

   task automatic put_digit_run(input int unsigned n);
      logic [7:0] d;
      repeat (n) begin
         d = DIGIT_LOW + 8'($urandom_range(9));
         msg_buf.push_back(d);
      end
   endtask

   // Mostly short values, now and then long enough to wrap 32 bits.
   task automatic put_digits();
      if ($urandom_range(19) == 0)
         put_digit_run($urandom_range(24, 12));
      else
         put_digit_run($urandom_range(10));
   endtask

   task automatic put_random_bytes(input int unsigned n);
      logic [7:0] d;
      repeat (n) begin
         d = 8'($urandom_range(255));
         msg_buf.push_back(d);
      end
   endtask

   // Well-formed message for a command, random values and closing byte.
   task automatic put_command(input cmd_code_type code);
      case (code)
         CMD_HELP: begin
            put_text("h\n");
            if ($urandom_range(3) == 0) put_random_bytes($urandom_range(6, 1));
         end
         CMD_BLINK: begin
            put_text("blink %"); put_digits(); put_text("% %"); put_digits(); put_text("%");
         end
         CMD_FADE: begin
            put_text("fade %"); put_digits(); put_text("% %"); put_digits(); put_text("%");
         end
         CMD_FADE_ON: begin
            put_text("fade on %"); put_digits(); put_text("%");
         end
         CMD_FADE_OFF: begin
            put_text("fade off %"); put_digits(); put_text("%");
         end
         CMD_STOP: begin
            put_text("stop\n");
            if ($urandom_range(3) == 0) put_random_bytes($urandom_range(6, 1));
         end
         default: put_random_bytes($urandom_range(16, 1));
      endcase
      // value commands need one closing byte after the last mark
      if (code inside {CMD_BLINK, CMD_FADE, CMD_FADE_ON, CMD_FADE_OFF}) begin
         if ($urandom_range(3) == 0) put_random_bytes(1);
         else put_text("\n");
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Each good command once, unknown text, plus byte extremes and a too-short prefix.
   task automatic test_commands();
      put_text("h\n");                       send_message();
      put_text("blink %12% %345%\n");        send_message();
      put_text("fade %4294967295% %0%\n");   send_message();
      put_text("fade on %7%\n");             send_message();
      put_text("fade off %%\n");             send_message();  // empty value reads 0
      put_text("stop\n");                    send_message();
      put_text("hello\n");                   send_message();
      put_text("h");                         send_message();  // shorter than any prefix
      msg_buf.push_back(8'h00);
      msg_buf.push_back(8'hFF);
      send_message();
      wait_results_done();
   endtask

   // Each value check failing on its own, mark saturation, value wrap.
   task automatic test_value_errors();
      put_text("blink %1%\n");               send_message();  // two marks, four needed
      put_text("fade on %1%xy");             send_message();  // closing mark too early
      put_text("blink %1%-%2%\n");           send_message();  // gap not a space
      put_text("fade %1%  %2%\n");           send_message();  // gap too wide
      put_text("fade off %1a%\n");           send_message();  // non-digit in value
      put_text("blink %%%%%%%%%%\n");        send_message();  // count pins at 7
      put_text("fade on %99999999999%\n");   send_message();  // wraps mod 2^32
      wait_results_done();
   endtask

   // Message exactly at the size limit, one byte over, and far over.
   task automatic test_long_messages();
      put_text("fade on %"); put_digit_run(MAX_BYTES - 11); put_text("%\n");
      send_message();
      put_text("fade on %"); put_digit_run(MAX_BYTES - 10); put_text("%\n");
      send_message();
      put_text("blink %1% %2%"); put_random_bytes(MAX_BYTES + 30);
      send_message();
      wait_results_done();
   endtask

   // Receiver holds off a long time while short messages keep coming, so
   // the result register fills, a last byte parks in the input register
   // and the block pushes back on the byte side.
   task automatic test_backpressure();
      int n;
      hold_request = 1'b1;
      for (n = 0; n < 40; n++) begin
         case (n % 3)
            0: put_text("h\n");
            1: put_text("stop\n");
            default: put_command(CMD_FADE_ON);
         endcase
         send_message();
      end
      wait_results_done();
   endtask

   // Mostly well-formed commands with random values, some corrupted,
   // some pure noise. Starts with a stretch where neither side idles.
   task automatic test_random_messages();
      int unsigned first_byte;
      int unsigned pick;
      int unsigned spot;
      logic [7:0]  d;
      first_byte = sent_bytes;
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      while (sent_bytes - first_byte < RANDOM_BYTES) begin
         if (sent_bytes - first_byte > 120) begin
            tx_idle_on = 1'b1;
            rx_idle_on = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            put_command(cmd_code_type'($urandom_range(CMD_STOP)));
         end else if (pick < 85) begin
            // broken: one byte replaced, sometimes a byte dropped or added
            put_command(cmd_code_type'($urandom_range(CMD_STOP)));
            spot = $urandom_range(msg_buf.size() - 1);
            d    = 8'($urandom_range(255));
            msg_buf[spot] = d;
            if (msg_buf.size() > 1 && $urandom_range(3) == 0)
               msg_buf.delete($urandom_range(msg_buf.size() - 1));
            if ($urandom_range(3) == 0)
               put_random_bytes(1);
         end else begin
            put_command(CMD_UNKNOWN);
         end
         send_message();
         if ($urandom_range(39) == 0)
            wait_results_done();
      end
   endtask

   initial begin
      clear_scan();
      held_first  = '0;
      held_second = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_commands();
      test_value_errors();
      test_long_messages();
      test_backpressure();
      test_random_messages();

      wait_results_done();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/cmdp_pkg.sv
hdl/cmdp_in_reg.sv
hdl/cmdp_scan.sv
hdl/terminal_command_parser.sv
tb/sv/tb_terminal_command_parser.sv
